FILE: hdl/i2cseq_pkg.sv
// shared types and constants for the i2c master transfer sequencer
`default_nettype none

package i2cseq_pkg;

   // field widths
   localparam int LEN_WIDTH           = 16;
   localparam int ADDR_WIDTH          = 7;
   localparam int BYTE_WIDTH          = 8;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // master status byte
   localparam logic [7:0] ST_RIF      = 8'h80;
   localparam logic [7:0] ST_WIF      = 8'h40;
   localparam logic [7:0] ST_CLKHOLD  = 8'h20;
   localparam logic [7:0] ST_RXNACK   = 8'h10;
   localparam logic [7:0] ST_ARBLOST  = 8'h08;
   localparam logic [7:0] ST_BUSERR   = 8'h04;
   localparam logic [7:0] ST_OWNER    = 8'h02;
   localparam logic [7:0] ST_READ_OK  = ST_RIF | ST_CLKHOLD | ST_OWNER;
   localparam logic [7:0] ST_WRITE_OK = ST_WIF | ST_CLKHOLD | ST_OWNER;
   localparam logic [7:0] ST_ERROR    = ST_ARBLOST | ST_BUSERR;

   // request kinds
   typedef enum logic [1:0] {
      OP_START_WR_RD = 2'd0,
      OP_START_WR_WR = 2'd1,
      OP_STATUS      = 2'd2
   } op_type;

   // commands to the master core
   typedef enum logic [2:0] {
      CMD_NONE        = 3'd0,
      CMD_SEND        = 3'd1,
      CMD_ACKREAD     = 3'd2,
      CMD_START_READ  = 3'd3,
      CMD_START_WRITE = 3'd4,
      CMD_NACK_STOP   = 3'd5
   } command_type;

   // one response transaction
   typedef struct packed {
      logic                  busy_res;
      logic                  ok;
      logic [BYTE_WIDTH-1:0] rx_data;
      logic [LEN_WIDTH-1:0]  rx_index;
      logic                  rx_valid;
      logic [LEN_WIDTH-1:0]  tx_index;
      logic                  tx_segment;
      logic [BYTE_WIDTH-1:0] address_byte;
   } rsp_payload_type;

endpackage : i2cseq_pkg

`default_nettype wire

FILE: hdl/i2c_master_transfer_sequencer.sv
// i2c master transfer sequencer: start and status decisions for one bus transaction
// A response is in the output register in the cycle after its request is taken.
// Throughput: one request per cycle while responses are taken; the single decision
// stage between the state registers and the output register sets this figure.
// The request side stalls only while the output register holds an untaken response.
// Reset (synchronous, active high) clears the state, the target address and the
// output register valid; the block takes requests in the first cycle after reset.
`default_nettype none

module i2c_master_transfer_sequencer
   import i2cseq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,   // target_address
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: first_len[15:0] second_len[31:16] read_len[47:32] read_present[48]
   //        bus_status[56:49] bus_data[64:57] zero fill[71:65]
   input  wire logic [71:0] req_tdata,
   input  wire logic [1:0]  req_tuser,     // op
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: address_byte[7:0] tx_segment[8] tx_index[24:9] rx_valid[25]
   //        rx_index[41:26] rx_data[49:42] ok[50] busy_res[51] zero fill[55:52]
   output logic [55:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,     // command
   output logic             rsp_tlast      // done_res
);

   localparam int PAYLOAD_WIDTH = $bits(rsp_payload_type);

   // request fields
   logic [LEN_WIDTH-1:0]  first_len;
   logic [LEN_WIDTH-1:0]  second_len;
   logic [LEN_WIDTH-1:0]  read_len;
   logic                  read_present;
   logic [BYTE_WIDTH-1:0] bus_status;
   logic [BYTE_WIDTH-1:0] bus_data;
   logic                  req_fire;

   assign first_len    = req_tdata[15:0];
   assign second_len   = req_tdata[31:16];
   assign read_len     = req_tdata[47:32];
   assign read_present = req_tdata[48];
   assign bus_status   = req_tdata[56:49];
   assign bus_data     = req_tdata[64:57];

   // transaction state
   logic [ADDR_WIDTH-1:0]  target_address_ff;
   logic                   active_ff, active_in;
   logic [COUNT_WIDTH-1:0] first_sent_ff, first_sent_in;
   logic [COUNT_WIDTH-1:0] first_total_ff, first_total_in;
   logic [COUNT_WIDTH-1:0] second_sent_ff, second_sent_in;
   logic [COUNT_WIDTH-1:0] second_total_ff, second_total_in;
   logic [COUNT_WIDTH-1:0] read_count_ff, read_count_in;
   logic [COUNT_WIDTH-1:0] read_total_ff, read_total_in;
   logic                   read_wanted_ff, read_wanted_in;
   logic                   result_ok_ff, result_ok_in;

   // output register
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   command_type           rsp_command_ff, rsp_command_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [COUNT_WIDTH-1:0] read_count_inc;
   logic [COUNT_WIDTH-1:0] first_len_cnt;

   // accept while the output register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign read_count_inc = read_count_ff + COUNT_WIDTH'(1);
   assign first_len_cnt  = COUNT_WIDTH'(first_len);

   // decision logic for one request
   always_comb begin
      active_in       = active_ff;
      first_sent_in   = first_sent_ff;
      first_total_in  = first_total_ff;
      second_sent_in  = second_sent_ff;
      second_total_in = second_total_ff;
      read_count_in   = read_count_ff;
      read_total_in   = read_total_ff;
      read_wanted_in  = read_wanted_ff;
      result_ok_in    = result_ok_ff;
      rsp_payload_in  = '0;
      rsp_command_in  = CMD_NONE;
      rsp_done_in     = 1'b0;

      case (req_tuser)
         OP_START_WR_RD, OP_START_WR_WR: begin
            first_total_in = first_len_cnt;
            first_sent_in  = '0;
            second_sent_in = '0;
            read_count_in  = '0;
            if (req_tuser == OP_START_WR_RD) begin
               second_total_in = '0;
               read_total_in   = COUNT_WIDTH'(read_len);
               read_wanted_in  = read_present;
            end else begin
               second_total_in = COUNT_WIDTH'(second_len);
               read_total_in   = '0;
               read_wanted_in  = 1'b0;
            end
            if (req_tuser == OP_START_WR_WR || first_len_cnt != '0) begin
               rsp_command_in              = CMD_START_WRITE;
               rsp_payload_in.address_byte = {target_address_ff, 1'b0};
            end else begin
               rsp_command_in              = CMD_START_READ;
               rsp_payload_in.address_byte = {target_address_ff, 1'b1};
            end
            result_ok_in = 1'b0;
            active_in    = 1'b1;
         end
         OP_STATUS: begin
            if (active_ff) begin
               if ((bus_status & ST_ERROR) != '0) begin
                  // arbitration lost or bus error
                  rsp_command_in = CMD_NACK_STOP;
                  rsp_done_in    = 1'b1;
                  result_ok_in   = 1'b0;
                  active_in      = 1'b0;
               end else if (bus_status == ST_READ_OK) begin
                  // byte received
                  if (read_wanted_ff) begin
                     rsp_payload_in.rx_valid = 1'b1;
                     rsp_payload_in.rx_index = LEN_WIDTH'(read_count_ff);
                     rsp_payload_in.rx_data  = bus_data;
                  end
                  read_count_in = read_count_inc;
                  if (read_count_inc < read_total_ff) begin
                     rsp_command_in = CMD_ACKREAD;
                  end else begin
                     rsp_command_in = CMD_NACK_STOP;
                     rsp_done_in    = 1'b1;
                     result_ok_in   = 1'b1;
                     active_in      = 1'b0;
                  end
               end else if (bus_status == ST_WRITE_OK) begin
                  // byte sent, pick the next step
                  if (first_sent_ff < first_total_ff) begin
                     rsp_command_in            = CMD_SEND;
                     rsp_payload_in.tx_segment = 1'b0;
                     rsp_payload_in.tx_index   = LEN_WIDTH'(first_sent_ff);
                     first_sent_in             = first_sent_ff + COUNT_WIDTH'(1);
                  end else if (second_sent_ff < second_total_ff) begin
                     rsp_command_in            = CMD_SEND;
                     rsp_payload_in.tx_segment = 1'b1;
                     rsp_payload_in.tx_index   = LEN_WIDTH'(second_sent_ff);
                     second_sent_in            = second_sent_ff + COUNT_WIDTH'(1);
                  end else if (read_wanted_ff) begin
                     rsp_command_in              = CMD_START_READ;
                     rsp_payload_in.address_byte = {target_address_ff, 1'b1};
                  end else begin
                     rsp_command_in = CMD_NACK_STOP;
                     rsp_done_in    = 1'b1;
                     result_ok_in   = 1'b1;
                     active_in      = 1'b0;
                  end
               end else begin
                  // unexpected status
                  rsp_command_in = CMD_NACK_STOP;
                  rsp_done_in    = 1'b1;
                  result_ok_in   = 1'b0;
                  active_in      = 1'b0;
               end
            end
         end
         default: begin
            rsp_command_in = CMD_NONE;
         end
      endcase

      rsp_payload_in.ok       = result_ok_in;
      rsp_payload_in.busy_res = active_in;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= '0;
      end else if (csr_wr_en) begin
         target_address_ff <= csr_wr_data;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         first_sent_ff   <= '0;
         first_total_ff  <= '0;
         second_sent_ff  <= '0;
         second_total_ff <= '0;
         read_count_ff   <= '0;
         read_total_ff   <= '0;
         read_wanted_ff  <= 1'b0;
         result_ok_ff    <= 1'b0;
      end else if (req_fire) begin
         active_ff       <= active_in;
         first_sent_ff   <= first_sent_in;
         first_total_ff  <= first_total_in;
         second_sent_ff  <= second_sent_in;
         second_total_ff <= second_total_in;
         read_count_ff   <= read_count_in;
         read_total_ff   <= read_total_in;
         read_wanted_ff  <= read_wanted_in;
         result_ok_ff    <= result_ok_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
         rsp_command_ff <= rsp_command_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(56 - PAYLOAD_WIDTH)'(0), rsp_payload_ff};
   assign rsp_tuser  = rsp_command_ff;
   assign rsp_tlast  = rsp_done_ff;

   // busy flag of a fresh response matches the transaction state
   assert property (@(posedge clock) disable iff (reset)
      $past(req_fire) && !$past(reset) |-> rsp_payload_ff.busy_res == active_ff)
      else $error("busy flag differs from transaction state");

   // segment one never sends past its length
   assert property (@(posedge clock) disable iff (reset)
      first_sent_ff <= first_total_ff)
      else $error("segment one index past its length");

   // segment two never sends past its length
   assert property (@(posedge clock) disable iff (reset)
      second_sent_ff <= second_total_ff)
      else $error("segment two index past its length");

   // a finished transaction leaves the block idle with a stop command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |->
         rsp_command_ff == CMD_NACK_STOP && !rsp_payload_ff.busy_res)
      else $error("finish without stop or still busy");

   // stored read bytes only come with read commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.rx_valid |->
         rsp_command_ff == CMD_ACKREAD || rsp_command_ff == CMD_NACK_STOP)
      else $error("read byte stored outside a read step");

endmodule : i2c_master_transfer_sequencer

`default_nettype wire
